// ----- hw/rtl/box3x3_mipmap_downsampler_top_defines.svh -----
// ----------------------------------------------------------------------------
// box3x3_mipmap_downsampler_top_defines
// Assertion macros used by the downsampler top level.
// ----------------------------------------------------------------------------
`ifndef BOX3X3_MIPMAP_DOWNSAMPLER_TOP_DEFINES_SVH
`define BOX3X3_MIPMAP_DOWNSAMPLER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define B3MD_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define B3MD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- hw/rtl/b3md_pkg.sv -----
// ----------------------------------------------------------------------------
// b3md_pkg
// Types and constants of the 3x3 box mip downsampler.
// ----------------------------------------------------------------------------
package b3md_pkg;

	localparam int MAX_ROW_PIXELS = 1024;
	localparam int COL_W          = $clog2(MAX_ROW_PIXELS);
	localparam int HEIGHT_LIMIT   = 4096;
	localparam int ROW_W          = 12;
	localparam int WIDTH_W        = 11;
	localparam int HEIGHT_W       = 13;
	localparam int CFG_DATA_W     = 13;
	localparam int CFG_INDEX_W    = 2;
	localparam int CH_W           = 8;
	localparam int PIX_W          = 4 * CH_W;

	localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;

	// tap masks: bit 0 oldest (c-2 / r-2), bit 2 newest
	localparam logic [2:0] MASK_NONE      = 3'b000;
	localparam logic [2:0] MASK_NEWEST    = 3'b100;
	localparam logic [2:0] MASK_NO_OLDEST = 3'b110;
	localparam logic [2:0] MASK_ALL       = 3'b111;

	localparam int Q_DEPTH   = 4;
	localparam int Q_PTR_W   = $clog2(Q_DEPTH);
	localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
	localparam int OUT_DEPTH = 8;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	localparam int COLSUM_W = 10;
	localparam int SUM_W    = 12;
	localparam int RECIP_W  = 13;
	localparam int PROD_W   = SUM_W + RECIP_W;
	localparam int RECIP_SHIFT = 16;
	// ceil(2^16 / 9); exact floor(x/9) for x below 2^12
	localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;

	typedef struct packed {
		logic [CH_W-1:0] alpha;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} pixel_t;

	typedef struct packed {
		pixel_t           pixel;
		logic [COL_W-1:0] col;
		logic [2:0]       colmask;
		logic [2:0]       rowmask;
		logic             emit;
		logic             last;
	} item_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] alpha;
		logic            last;
	} result_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	typedef struct packed {
		logic                 q_pop;
		logic                 out_push;
		logic [OUT_CNT_W-1:0] out_cnt;
	} back_stat_t;

	function automatic logic [CH_W-1:0] get_channel(input pixel_t p, input logic [1:0] k);
		logic [PIX_W-1:0] bits;
		bits = p;
		return bits[k*CH_W +: CH_W];
	endfunction

endpackage

// ----- hw/rtl/b3md_ram.sv -----
// ----------------------------------------------------------------------------
// b3md_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module b3md_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/b3md_front.sv -----
// ----------------------------------------------------------------------------
// b3md_front
// Holds the level size, tracks the source position and tags each pixel
// with its window masks before it enters the queue.
// ----------------------------------------------------------------------------
module b3md_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [b3md_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [b3md_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               push,
	input  b3md_pkg::pixel_t                   pixel,
	input  b3md_pkg::q_stat_t                  q_stat,
	output logic                               q_push,
	output b3md_pkg::item_t                    q_item
);

	logic [b3md_pkg::WIDTH_W-1:0]  width_q;
	logic [b3md_pkg::HEIGHT_W-1:0] height_q;
	logic [b3md_pkg::COL_W-1:0]    col_q;
	logic [b3md_pkg::ROW_W-1:0]    row_q;
	logic [b3md_pkg::COL_W-1:0]    w_m1;
	logic [b3md_pkg::ROW_W-1:0]    h_m1;
	logic [2:0]                    colmask;
	logic [2:0]                    rowmask;
	logic                          last_col;
	logic                          last_row;

	// clamp to 1..max, kept as size minus one
	always_comb begin
		priority if (width_q == '0) begin
			w_m1 = '0;
		end else if (width_q > b3md_pkg::WIDTH_W'(b3md_pkg::MAX_ROW_PIXELS)) begin
			w_m1 = b3md_pkg::COL_W'(b3md_pkg::MAX_ROW_PIXELS - 1);
		end else begin
			w_m1 = b3md_pkg::COL_W'(width_q - 1'b1);
		end
		priority if (height_q == '0) begin
			h_m1 = '0;
		end else if (height_q > b3md_pkg::HEIGHT_W'(b3md_pkg::HEIGHT_LIMIT)) begin
			h_m1 = b3md_pkg::ROW_W'(b3md_pkg::HEIGHT_LIMIT - 1);
		end else begin
			h_m1 = b3md_pkg::ROW_W'(height_q - 1'b1);
		end
	end

	assign last_col = (col_q == w_m1);
	assign last_row = (row_q == h_m1);

	// odd position closes a window centred one back; last even one closes
	// its own window with the far taps missing
	always_comb begin
		priority if (col_q[0]) begin
			colmask = (col_q == b3md_pkg::COL_W'(1)) ? b3md_pkg::MASK_NO_OLDEST
				: b3md_pkg::MASK_ALL;
		end else if (last_col) begin
			colmask = (col_q == '0) ? b3md_pkg::MASK_NEWEST : b3md_pkg::MASK_NO_OLDEST;
		end else begin
			colmask = b3md_pkg::MASK_NONE;
		end
		priority if (row_q[0]) begin
			rowmask = (row_q == b3md_pkg::ROW_W'(1)) ? b3md_pkg::MASK_NO_OLDEST
				: b3md_pkg::MASK_ALL;
		end else if (last_row) begin
			rowmask = (row_q == '0) ? b3md_pkg::MASK_NEWEST : b3md_pkg::MASK_NO_OLDEST;
		end else begin
			rowmask = b3md_pkg::MASK_NONE;
		end
	end

	assign q_push = push && !q_stat.full;

	always_comb begin
		q_item.pixel   = pixel;
		q_item.col     = col_q;
		q_item.colmask = colmask;
		q_item.rowmask = rowmask;
		q_item.emit    = (colmask != b3md_pkg::MASK_NONE) && (rowmask != b3md_pkg::MASK_NONE);
		q_item.last    = last_col && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= b3md_pkg::WIDTH_W'(8);
			height_q <= b3md_pkg::HEIGHT_W'(8);
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				b3md_pkg::REG_SOURCE_WIDTH: begin
					width_q <= cfg_data[b3md_pkg::WIDTH_W-1:0];
					col_q   <= '0;
					row_q   <= '0;
				end
				b3md_pkg::REG_SOURCE_HEIGHT: begin
					height_q <= cfg_data[b3md_pkg::HEIGHT_W-1:0];
					col_q    <= '0;
					row_q    <= '0;
				end
				default: begin
				end
			endcase
		end else if (q_push) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/b3md_queue.sv -----
// ----------------------------------------------------------------------------
// b3md_queue
// Short queue of tagged pixels between the front and the filter back end.
// ----------------------------------------------------------------------------
module b3md_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  b3md_pkg::item_t   push_item,
	input  logic              pop,
	output b3md_pkg::item_t   head,
	output b3md_pkg::q_stat_t stat
);

	b3md_pkg::item_t                 mem_q [b3md_pkg::Q_DEPTH];
	logic [b3md_pkg::Q_PTR_W-1:0]    wr_ptr_q;
	logic [b3md_pkg::Q_PTR_W-1:0]    rd_ptr_q;
	logic [b3md_pkg::Q_CNT_W-1:0]    cnt_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == b3md_pkg::Q_CNT_W'(b3md_pkg::Q_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- hw/rtl/b3md_back.sv -----
// ----------------------------------------------------------------------------
// b3md_back
// Line stores, 3x3 window, masked sums, divide by nine and result queue.
// s1: store data back, write stores, shift window; s2: column sums;
// s3: window sums; s4: divide into the result queue.
// ----------------------------------------------------------------------------
module b3md_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  b3md_pkg::item_t      q_head,
	input  b3md_pkg::q_stat_t    q_stat,
	input  logic                 pop,
	output logic                 empty,
	output b3md_pkg::result_t    head,
	output b3md_pkg::back_stat_t stat
);

	logic                                q_pop;
	logic [b3md_pkg::OUT_CNT_W:0]        credit_use;

	logic                                valid_s1;
	b3md_pkg::item_t                     item_s1;
	logic                                fwd_s1;
	b3md_pkg::pixel_t                    older_rd;
	b3md_pkg::pixel_t                    newer_rd;
	b3md_pkg::pixel_t                    older_eff;
	b3md_pkg::pixel_t                    newer_eff;
	b3md_pkg::pixel_t                    wr_older_q;
	b3md_pkg::pixel_t                    wr_newer_q;
	b3md_pkg::pixel_t                    win_q [3][3];

	logic                                valid_s2;
	logic [2:0]                          colmask_s2;
	logic [2:0]                          rowmask_s2;
	logic                                last_s2;
	logic [b3md_pkg::COLSUM_W-1:0]       colsum_d [3][4];

	logic                                valid_s3;
	logic                                last_s3;
	logic [b3md_pkg::COLSUM_W-1:0]       colsum_s3 [3][4];

	logic                                valid_s4;
	logic                                last_s4;
	logic [b3md_pkg::SUM_W-1:0]          sum_s4 [4];
	logic [b3md_pkg::CH_W-1:0]           quot [4];

	b3md_pkg::result_t                   fifo_q [b3md_pkg::OUT_DEPTH];
	logic [b3md_pkg::OUT_PTR_W-1:0]      wr_ptr_q;
	logic [b3md_pkg::OUT_PTR_W-1:0]      rd_ptr_q;
	logic [b3md_pkg::OUT_CNT_W-1:0]      cnt_q;
	logic                                out_pop;
	b3md_pkg::result_t                   res;

	// every result in flight holds a slot in the result queue
	assign credit_use = (b3md_pkg::OUT_CNT_W + 1)'(cnt_q)
		+ (b3md_pkg::OUT_CNT_W + 1)'(valid_s1 && item_s1.emit)
		+ (b3md_pkg::OUT_CNT_W + 1)'(valid_s2)
		+ (b3md_pkg::OUT_CNT_W + 1)'(valid_s3)
		+ (b3md_pkg::OUT_CNT_W + 1)'(valid_s4);
	assign q_pop = !q_stat.empty
		&& (credit_use < (b3md_pkg::OUT_CNT_W + 1)'(b3md_pkg::OUT_DEPTH));

	b3md_ram #(
		.WIDTH(b3md_pkg::PIX_W),
		.DEPTH(b3md_pkg::MAX_ROW_PIXELS)
	) u_older_ram (
		.clk  (clk),
		.we   (valid_s1),
		.waddr(item_s1.col),
		.wdata(newer_eff),
		.raddr(q_head.col),
		.rdata(older_rd)
	);

	b3md_ram #(
		.WIDTH(b3md_pkg::PIX_W),
		.DEPTH(b3md_pkg::MAX_ROW_PIXELS)
	) u_newer_ram (
		.clk  (clk),
		.we   (valid_s1),
		.waddr(item_s1.col),
		.wdata(item_s1.pixel),
		.raddr(q_head.col),
		.rdata(newer_rd)
	);

	// one-pixel rows read the column written on the same edge
	assign older_eff = fwd_s1 ? wr_older_q : older_rd;
	assign newer_eff = fwd_s1 ? wr_newer_q : newer_rd;

	always_comb begin
		for (int ci = 0; ci < 3; ci++) begin
			for (int k = 0; k < 4; k++) begin
				colsum_d[ci][k] = '0;
				for (int ri = 0; ri < 3; ri++) begin
					if (colmask_s2[ci] && rowmask_s2[ri]) begin
						colsum_d[ci][k] = colsum_d[ci][k] + b3md_pkg::COLSUM_W'(
							b3md_pkg::get_channel(win_q[ci][ri], 2'(k)));
					end
				end
			end
		end
	end

	always_comb begin
		logic [b3md_pkg::PROD_W-1:0] prod;
		for (int k = 0; k < 4; k++) begin
			prod = b3md_pkg::PROD_W'(sum_s4[k]) * b3md_pkg::PROD_W'(b3md_pkg::RECIP_NINE);
			quot[k] = prod[b3md_pkg::RECIP_SHIFT +: b3md_pkg::CH_W];
		end
		res.red   = quot[0];
		res.green = quot[1];
		res.blue  = quot[2];
		res.alpha = quot[3];
		res.last  = last_s4;
	end

	// payload
	always_ff @(posedge clk) begin
		item_s1 <= q_head;
		fwd_s1  <= valid_s1 && (item_s1.col == q_head.col);
		if (valid_s1) begin
			wr_older_q  <= newer_eff;
			wr_newer_q  <= item_s1.pixel;
			win_q[0]    <= win_q[1];
			win_q[1]    <= win_q[2];
			win_q[2][0] <= older_eff;
			win_q[2][1] <= newer_eff;
			win_q[2][2] <= item_s1.pixel;
		end
		colmask_s2 <= item_s1.colmask;
		rowmask_s2 <= item_s1.rowmask;
		last_s2    <= item_s1.last;
		colsum_s3  <= colsum_d;
		last_s3    <= last_s2;
		for (int k = 0; k < 4; k++) begin
			sum_s4[k] <= b3md_pkg::SUM_W'(colsum_s3[0][k]) + b3md_pkg::SUM_W'(colsum_s3[1][k])
				+ b3md_pkg::SUM_W'(colsum_s3[2][k]);
		end
		last_s4 <= last_s3;
		if (valid_s4) begin
			fifo_q[wr_ptr_q] <= res;
		end
	end

	assign out_pop = pop && (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			valid_s1 <= q_pop;
			valid_s2 <= valid_s1 && item_s1.emit;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			if (valid_s4) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (out_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({valid_s4, out_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign empty         = (cnt_q == '0);
	assign head          = fifo_q[rd_ptr_q];
	assign stat.q_pop    = q_pop;
	assign stat.out_push = valid_s4;
	assign stat.out_cnt  = cnt_q;

endmodule

// ----- hw/rtl/box3x3_mipmap_downsampler_top.sv -----
// A result goes through the input queue, stages s1 to s4 and the result queue
// to the outputs; throughput is one source pixel per cycle while the queues
// have room, set by the row stores (one read and one write port each, every cycle).
// Reset: arst_n clears positions, queues and pipeline valids and sets the
// level to 8x8; row stores keep their contents, no clearing pass.
// ----------------------------------------------------------------------------
// box3x3_mipmap_downsampler_top
// 3x3 box filter with decimation by two for RGBA8 mip level generation.
// ----------------------------------------------------------------------------
`include "box3x3_mipmap_downsampler_top_defines.svh"

module box3x3_mipmap_downsampler_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [b3md_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [b3md_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             push,
	output logic                             full,
	input  logic [b3md_pkg::CH_W-1:0]        in_red,
	input  logic [b3md_pkg::CH_W-1:0]        in_green,
	input  logic [b3md_pkg::CH_W-1:0]        in_blue,
	input  logic [b3md_pkg::CH_W-1:0]        in_alpha,
	output logic                             empty,
	input  logic                             pop,
	output logic [b3md_pkg::CH_W-1:0]        out_red,
	output logic [b3md_pkg::CH_W-1:0]        out_green,
	output logic [b3md_pkg::CH_W-1:0]        out_blue,
	output logic [b3md_pkg::CH_W-1:0]        out_alpha,
	output logic                             level_done
);

	b3md_pkg::pixel_t     pixel;
	b3md_pkg::q_stat_t    q_stat;
	b3md_pkg::item_t      push_item;
	b3md_pkg::item_t      q_head;
	b3md_pkg::result_t    res_head;
	b3md_pkg::back_stat_t back_stat;
	logic                 q_push;

	always_comb begin
		pixel.red   = in_red;
		pixel.green = in_green;
		pixel.blue  = in_blue;
		pixel.alpha = in_alpha;
	end

	b3md_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.push     (push),
		.pixel    (pixel),
		.q_stat   (q_stat),
		.q_push   (q_push),
		.q_item   (push_item)
	);

	b3md_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(push_item),
		.pop      (back_stat.q_pop),
		.head     (q_head),
		.stat     (q_stat)
	);

	b3md_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.q_head(q_head),
		.q_stat(q_stat),
		.pop   (pop),
		.empty (empty),
		.head  (res_head),
		.stat  (back_stat)
	);

	assign full       = q_stat.full;
	assign out_red    = res_head.red;
	assign out_green  = res_head.green;
	assign out_blue   = res_head.blue;
	assign out_alpha  = res_head.alpha;
	assign level_done = res_head.last;

	// result queue never overflows: credit covers every result in flight
	`B3MD_ASSERT_IMPLY(a_out_no_overflow, back_stat.out_push,
		(back_stat.out_cnt != b3md_pkg::OUT_CNT_W'(b3md_pkg::OUT_DEPTH)) || pop)
	`B3MD_ASSERT_IMPLY(a_pop_nonempty, back_stat.q_pop, !q_stat.empty)
	`B3MD_ASSERT_NEXT(a_accept_queued, push && !full, !q_stat.empty)

endmodule
